// File: hdl/sil_pkg.sv
`timescale 1ns / 1ps
// Package for the serial image loader: sizes, item and phase types, status codes.
// Used by every module under hdl; depends on nothing else.
package sil_pkg;

  localparam int INDEX_BITS = 24;
  localparam int REM_W = INDEX_BITS + 1;
  localparam int WIDX_W = 24;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] SIG_RESET = 32'h4788_cafe;
  localparam logic [30:0] MAX_WORDS = 31'(1) << INDEX_BITS;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_SIG     = 5'b00010,
    PH_SIZE    = 5'b00100,
    PH_CHECK   = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_OK     = 3'd1,
    ST_BADSIG = 3'd2,
    ST_BADSUM = 3'd3,
    ST_TOOBIG = 3'd4
  } status_t;

  typedef struct packed {
    logic                  write_valid;
    logic [WIDX_W-1:0]     write_index;
    logic [31:0]           write_data;
    logic                  done_res;
    status_t               status;
  } result_t;

endpackage

// File: hdl/sil_front.sv
`timescale 1ns / 1ps
// Front stage: accepts requests from the input channel and classifies them.
// Depends on sil_pkg.
module sil_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_cmd,
  input  logic [7:0]     in_data_byte,
  output logic           q_valid,
  input  logic           q_ready,
  output sil_pkg::item_t q_item
);

  logic           valid_r, valid_nxt;
  sil_pkg::item_t item_r, item_nxt;

  assign in_ready = !valid_r || q_ready;
  assign q_valid  = valid_r;
  assign q_item   = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_valid && in_ready) begin
      valid_nxt    = 1'b1;
      item_nxt.op  = in_cmd ? sil_pkg::OP_DATA : sil_pkg::OP_START;
      item_nxt.data = in_data_byte;
    end else if (q_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

// File: hdl/sil_queue.sv
`timescale 1ns / 1ps
// Short queue of classified requests between the front and the back.
// Depends on sil_pkg.
module sil_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  sil_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output sil_pkg::item_t pop_item
);

  localparam int PTR_W = $clog2(sil_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(sil_pkg::QUEUE_DEPTH + 1);

  sil_pkg::item_t   mem_r [sil_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(sil_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(sil_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(sil_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hdl/sil_back.sv
`timescale 1ns / 1ps
// Back end: image parser state, signature register and the registered result.
// Depends on sil_pkg.
module sil_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr,
  input  logic [31:0]      cfg_data,
  input  logic             q_valid,
  output logic             q_ready,
  input  sil_pkg::item_t   q_item,
  output logic             res_valid,
  input  logic             res_ready,
  output sil_pkg::result_t res
);

  sil_pkg::phase_t          phase_r, phase_nxt;
  logic [1:0]               pos_r, pos_nxt;
  logic [23:0]              asm_r, asm_nxt;
  logic [sil_pkg::REM_W-1:0]      remain_r, remain_nxt;
  logic [sil_pkg::INDEX_BITS-1:0] idx_r, idx_nxt;
  logic [31:0]              acc_r, acc_nxt;
  logic [31:0]              sig_r;
  logic                     out_valid_r, out_valid_nxt;
  sil_pkg::result_t         out_r, out_nxt;

  logic        take;
  logic [7:0]  b;
  logic [7:0]  expect_byte;
  logic [31:0] word;
  logic [31:0] sum;
  logic [29:0] n_words;

  assign take        = q_valid && (!out_valid_r || res_ready);
  assign q_ready     = !out_valid_r || res_ready;
  assign res_valid   = out_valid_r;
  assign res         = out_r;
  assign b           = q_item.data;
  assign expect_byte = 8'(sig_r >> {pos_r, 3'b000});
  assign word        = {b, asm_r};
  assign sum         = acc_r + word;
  assign n_words     = word[31:2];

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    asm_nxt       = asm_r;
    remain_nxt    = remain_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      if (q_item.op == sil_pkg::OP_START) begin
        phase_nxt  = sil_pkg::PH_SIG;
        pos_nxt    = '0;
        asm_nxt    = '0;
        remain_nxt = '0;
        idx_nxt    = '0;
        acc_nxt    = '0;
      end else begin
        unique case (phase_r)
          sil_pkg::PH_IDLE: begin
          end
          sil_pkg::PH_SIG: begin
            if (b != expect_byte) begin
              phase_nxt       = sil_pkg::PH_IDLE;
              out_nxt.done_res = 1'b1;
              out_nxt.status  = sil_pkg::ST_BADSIG;
            end else if (pos_r == 2'd3) begin
              pos_nxt   = '0;
              phase_nxt = sil_pkg::PH_SIZE;
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end
          sil_pkg::PH_SIZE, sil_pkg::PH_CHECK, sil_pkg::PH_PAYLOAD: begin
            if (pos_r != 2'd3) begin
              asm_nxt = {b, asm_r[23:8]};
              pos_nxt = pos_r + 1'b1;
            end else begin
              pos_nxt = '0;
              asm_nxt = '0;
              if (phase_r == sil_pkg::PH_SIZE) begin
                if ({1'b0, n_words} > sil_pkg::MAX_WORDS) begin
                  phase_nxt        = sil_pkg::PH_IDLE;
                  out_nxt.done_res = 1'b1;
                  out_nxt.status   = sil_pkg::ST_TOOBIG;
                end else begin
                  remain_nxt = sil_pkg::REM_W'(n_words);
                  phase_nxt  = sil_pkg::PH_CHECK;
                end
              end else if (phase_r == sil_pkg::PH_CHECK) begin
                acc_nxt = word;
                if (remain_r == '0) begin
                  phase_nxt        = sil_pkg::PH_IDLE;
                  out_nxt.done_res = 1'b1;
                  out_nxt.status   = (word == '0) ? sil_pkg::ST_OK : sil_pkg::ST_BADSUM;
                end else begin
                  phase_nxt = sil_pkg::PH_PAYLOAD;
                end
              end else begin
                out_nxt.write_valid = 1'b1;
                out_nxt.write_index = sil_pkg::WIDX_W'(idx_r);
                out_nxt.write_data  = word;
                acc_nxt    = sum;
                idx_nxt    = idx_r + 1'b1;
                remain_nxt = remain_r - 1'b1;
                if (remain_r == sil_pkg::REM_W'(1)) begin
                  phase_nxt        = sil_pkg::PH_IDLE;
                  out_nxt.done_res = 1'b1;
                  out_nxt.status   = (sum == '0) ? sil_pkg::ST_OK : sil_pkg::ST_BADSUM;
                end
              end
            end
          end
          default: begin
            phase_nxt = sil_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sil_pkg::PH_IDLE;
      pos_r       <= '0;
      asm_r       <= '0;
      remain_r    <= '0;
      idx_r       <= '0;
      acc_r       <= '0;
      sig_r       <= sil_pkg::SIG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      asm_r       <= asm_nxt;
      remain_r    <= remain_nxt;
      idx_r       <= idx_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        sig_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

// File: hdl/serial_image_loader.sv
`timescale 1ns / 1ps
// Serial image loader top level: front stage, request queue and parser back end.
// Throughput is one request per cycle while out_ready is not held low; a result passes
// through the front register, a queue entry and the result register before it is offered.
// Reset is synchronous and active low; it empties the pipeline, returns the parser
// to idle and loads the signature register with 0x4788cafe. Depends on sil_pkg.
module serial_image_loader (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [31:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_cmd,
  input  logic [7:0]                in_data_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_write_valid,
  output logic [sil_pkg::WIDX_W-1:0] out_write_index,
  output logic [31:0]               out_write_data,
  output logic                      out_done_res,
  output logic [2:0]                out_status
);

  logic             f_valid, f_ready;
  sil_pkg::item_t   f_item;
  logic             b_valid, b_ready;
  sil_pkg::item_t   b_item;
  sil_pkg::result_t res;

  assign cfg_ready = 1'b1;

  sil_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .q_valid      (f_valid),
    .q_ready      (f_ready),
    .q_item       (f_item)
  );

  sil_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_item   (b_item)
  );

  sil_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_item    (b_item),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_write_valid = res.write_valid;
  assign out_write_index = res.write_index;
  assign out_write_data  = res.write_data;
  assign out_done_res    = res.done_res;
  assign out_status      = res.status;

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for serial_image_loader: sends start and data requests, predicts
// every result as each request is accepted and checks each field as the result leaves.
// Depends on sil_pkg and serial_image_loader; needs nothing else.
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_SHARE = 420;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = 1'b0;
  logic [7:0] in_data_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_write_valid;
  logic [sil_pkg::WIDX_W-1:0] out_write_index;
  logic [31:0] out_write_data;
  logic out_done_res;
  logic [2:0] out_status;

  serial_image_loader dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_write_valid (out_write_valid),
    .out_write_index (out_write_index),
    .out_write_data  (out_write_data),
    .out_done_res    (out_done_res),
    .out_status      (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] sig_value;
  sil_pkg::phase_t ld_phase;
  logic [1:0] ld_pos;
  logic [23:0] ld_acc;
  logic [sil_pkg::INDEX_BITS:0] ld_words;
  logic [31:0] ld_check;
  logic [31:0] ld_sum;
  logic [sil_pkg::INDEX_BITS:0] ld_written;
  sil_pkg::result_t due_results[$];

  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  logic hold_rx = 1'b0;
  int unsigned rx_gap = 0;
  int unsigned quiet_cycles = 0;
  int unsigned reqs_sent = 0;
  int unsigned cfg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned payload_writes = 0;
  int unsigned endings[5] = '{default: 0};

  task automatic clear_load_state;
    ld_pos = '0;
    ld_acc = '0;
    ld_words = '0;
    ld_check = '0;
    ld_sum = '0;
    ld_written = '0;
  endtask

  function automatic sil_pkg::status_t sum_verdict(input logic [31:0] total);
    return (total == 32'd0) ? sil_pkg::ST_OK : sil_pkg::ST_BADSUM;
  endfunction

  task automatic predict_loader(input sil_pkg::item_t req, output sil_pkg::result_t res);
    logic [31:0] word;
    res = '0;
    res.status = sil_pkg::ST_BUSY;
    if (req.op == sil_pkg::OP_START) begin
      clear_load_state();
      ld_phase = sil_pkg::PH_SIG;
    end else if (ld_phase == sil_pkg::PH_SIG) begin
      if (req.data != sig_value[8*ld_pos +: 8]) begin
        ld_phase = sil_pkg::PH_IDLE;
        res.done_res = 1'b1;
        res.status = sil_pkg::ST_BADSIG;
      end else begin
        if (ld_pos == 2'd3) ld_phase = sil_pkg::PH_SIZE;
        ld_pos = ld_pos + 2'd1;
      end
    end else if (ld_phase != sil_pkg::PH_IDLE) begin
      if (ld_pos != 2'd3) begin
        ld_acc = ld_acc | (24'(req.data) << (8 * ld_pos));
        ld_pos = ld_pos + 2'd1;
      end else begin
        word = {req.data, ld_acc};
        ld_pos = '0;
        ld_acc = '0;
        unique case (ld_phase)
          sil_pkg::PH_SIZE: begin
            if (32'(word[31:2]) > (32'd1 << sil_pkg::INDEX_BITS)) begin
              ld_phase = sil_pkg::PH_IDLE;
              res.done_res = 1'b1;
              res.status = sil_pkg::ST_TOOBIG;
            end else begin
              ld_words = word[sil_pkg::INDEX_BITS+2:2];
              ld_phase = sil_pkg::PH_CHECK;
            end
          end
          sil_pkg::PH_CHECK: begin
            ld_check = word;
            if (ld_words == '0) begin
              ld_phase = sil_pkg::PH_IDLE;
              res.done_res = 1'b1;
              res.status = sum_verdict(ld_sum + ld_check);
            end else begin
              ld_phase = sil_pkg::PH_PAYLOAD;
            end
          end
          default: begin
            res.write_valid = 1'b1;
            res.write_index = ld_written[sil_pkg::WIDX_W-1:0];
            res.write_data = word;
            ld_sum = ld_sum + word;
            ld_written = ld_written + 1'b1;
            if (ld_written >= ld_words) begin
              ld_phase = sil_pkg::PH_IDLE;
              res.done_res = 1'b1;
              res.status = sum_verdict(ld_sum + ld_check);
            end
          end
        endcase
      end
    end
  endtask

  task automatic report_error(input string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic send_req(input sil_pkg::op_t op, input logic [7:0] data);
    sil_pkg::item_t req;
    sil_pkg::result_t res;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= op;
    in_data_byte <= data;
    do @(posedge clk); while (!(in_valid && in_ready));
    req.op = op;
    req.data = data;
    predict_loader(req, res);
    due_results.push_back(res);
    reqs_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_req(sil_pkg::OP_DATA, w[8*i +: 8]);
  endtask

  task automatic send_header(input logic [31:0] size, input logic [31:0] check);
    send_req(sil_pkg::OP_START, 8'($urandom));
    send_word(sig_value);
    send_word(size);
    send_word(check);
  endtask

  task automatic send_bad_signature(input int pos);
    send_req(sil_pkg::OP_START, 8'($urandom));
    for (int i = 0; i < pos; i++) send_req(sil_pkg::OP_DATA, sig_value[8*i +: 8]);
    send_req(sil_pkg::OP_DATA, sig_value[8*pos +: 8] ^ 8'($urandom_range(1, 255)));
  endtask

  task automatic run_load(input int nwords, input bit good, input int extra);
    logic [31:0] words[$];
    logic [31:0] total;
    total = '0;
    for (int i = 0; i < nwords; i++) begin
      words.push_back($urandom);
      total = total + words[i];
    end
    send_header(32'(nwords * 4 + extra), good ? -total : $urandom);
    foreach (words[i]) send_word(words[i]);
    repeat (extra) send_req(sil_pkg::OP_DATA, 8'($urandom));
  endtask

  task automatic drain;
    if (in_valid) in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_signature(input logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    sig_value = value;
    cfg_writes++;
  endtask

  task automatic test_good_load;
    send_req(sil_pkg::OP_DATA, 8'h00);
    send_req(sil_pkg::OP_DATA, 8'hff);
    send_header(32'd11, 32'd1);
    send_word(32'h0000_0000);
    send_word(32'hffff_ffff);
    repeat (3) send_req(sil_pkg::OP_DATA, 8'h5a);
  endtask

  task automatic test_bad_signature;
    for (int pos = 0; pos < 4; pos++) send_bad_signature(pos);
    send_req(sil_pkg::OP_DATA, 8'h80);
  endtask

  task automatic test_checksum_cases;
    send_header(32'd0, 32'd0);
    send_header(32'd3, 32'h8000_0000);
    run_load(1, 1'b0, 0);
    send_header(32'd8, 32'd0);
    send_word($urandom);
    run_load(1, 1'b1, 0);
  endtask

  task automatic test_size_limits;
    send_header(32'h0400_0000, 32'd0);
    send_word($urandom);
    send_header(32'h0400_0004, 32'd0);
    send_header(32'hffff_ffff, 32'd0);
  endtask

  task automatic test_signature_register;
    logic [31:0] values[3];
    values = '{32'h0000_0000, 32'hffff_ffff, $urandom};
    foreach (values[i]) begin
      write_signature(values[i]);
      run_load(2, 1'b1, 0);
      send_bad_signature($urandom_range(0, 3));
    end
    write_signature(sil_pkg::SIG_RESET);
  endtask

  task automatic test_backpressure;
    drain();
    idle_on = 1'b0;
    hold_req = 1'b1;
    run_load(8, 1'b1, 1);
    drain();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(input int unsigned share);
    int unsigned stop_at;
    int pick;
    stop_at = reqs_sent + share;
    while (reqs_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        run_load($urandom_range(0, 6), 1'($urandom_range(0, 1)), $urandom_range(0, 3));
      end else if (pick < 70) begin
        run_load($urandom_range(7, 40), 1'b1, 0);
      end else if (pick < 80) begin
        send_bad_signature($urandom_range(0, 3));
      end else if (pick < 88) begin
        send_header($urandom_range(4, 40), $urandom);
        repeat ($urandom_range(0, 6)) send_req(sil_pkg::OP_DATA, 8'($urandom));
      end else if (pick < 93) begin
        send_header($urandom_range(32'h0400_0004, 32'hffff_ffff), $urandom);
      end else begin
        repeat ($urandom_range(1, 8))
          send_req(sil_pkg::op_t'($urandom_range(0, 1)), 8'($urandom));
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_rx) begin
      out_ready <= 1'b0;
    end else if (rx_gap != 0) begin
      out_ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (idle_on && $urandom_range(0, 6) == 0) begin
      out_ready <= 1'b0;
      rx_gap <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    sil_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report_error("result arrived with no request outstanding");
      end else begin
        want = due_results.pop_front();
        if (out_write_valid !== want.write_valid)
          report_error($sformatf("write_valid got %b expected %b",
                                 out_write_valid, want.write_valid));
        if (out_write_index !== want.write_index)
          report_error($sformatf("write_index got %0h expected %0h",
                                 out_write_index, want.write_index));
        if (out_write_data !== want.write_data)
          report_error($sformatf("write_data got %0h expected %0h",
                                 out_write_data, want.write_data));
        if (out_done_res !== want.done_res)
          report_error($sformatf("done_res got %b expected %b", out_done_res, want.done_res));
        if (out_status !== want.status)
          report_error($sformatf("status got %0d expected %0d", out_status, want.status));
        if (want.write_valid) payload_writes++;
        if (want.done_res) endings[want.status]++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out after %0d cycles with no request moving.", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clear_load_state();
    ld_phase = sil_pkg::PH_IDLE;
    sig_value = sil_pkg::SIG_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_good_load();
    test_bad_signature();
    test_checksum_cases();
    test_size_limits();
    test_signature_register();
    test_backpressure();
    test_random_traffic(RANDOM_SHARE);
    write_signature($urandom);
    test_random_traffic(RANDOM_SHARE);
    write_signature(sil_pkg::SIG_RESET);
    idle_on = 1'b0;
    test_random_traffic(RANDOM_SHARE);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests over %0d signature settings; %0d payload words were written.",
             reqs_sent, cfg_writes + 1, payload_writes);
    $display("Loads ended: %0d ok, %0d bad signature, %0d bad checksum, %0d too large.",
             endings[sil_pkg::ST_OK], endings[sil_pkg::ST_BADSIG],
             endings[sil_pkg::ST_BADSUM], endings[sil_pkg::ST_TOOBIG]);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/sil_pkg.sv
hdl/sil_front.sv
hdl/sil_queue.sv
hdl/sil_back.sv
hdl/serial_image_loader.sv
verif/tb.sv
